/* hw/rtl/dedup_receive_message_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the duplicate-suppressing receive queue
// Shared property forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEDUP_RECEIVE_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`define DEDUP_RECEIVE_MESSAGE_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication
`define DRMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DRMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/drmq_pkg.sv */
// ----------------------------------------------------------------------------
// drmq_pkg
// Types, sizes and codes shared by the receive queue controller and datapath.
// ----------------------------------------------------------------------------
package drmq_pkg;

  // Storage sizes
  localparam int QUEUE_DEPTH  = 16;
  localparam int RECENT_DEPTH = 16;
  localparam int STATIONS     = 8;

  localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RIDX_W   = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int HB_W     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int SCAN_LEN = (QUEUE_DEPTH > RECENT_DEPTH) ? QUEUE_DEPTH : RECENT_DEPTH;
  localparam int SIDX_W   = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

  // Field widths
  localparam int POS_W   = 3;
  localparam int ID_W    = 31;
  localparam int CMD_W   = 8;
  localparam int REF_W   = 16;
  localparam int TICK_W  = 32;
  localparam int ORDER_W = 32;
  localparam int LC_W    = 32;

  // Action codes
  localparam logic ACT_RECV  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef enum logic [1:0] {
    MK_RELIABLE   = 2'd0,
    MK_UNRELIABLE = 2'd1,
    MK_CONFIRM    = 2'd2,
    MK_HEARTBEAT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RS_QUEUED    = 3'd0,
    RS_DUP       = 3'd1,
    RS_CONFIRM   = 3'd2,
    RS_HEARTBEAT = 3'd3,
    RS_OWN       = 3'd4,
    RS_FULL      = 3'd5,
    RS_FETCHED   = 3'd6,
    RS_EMPTY     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } ctl_stat_t;

endpackage

/* hw/rtl/dedup_receive_message_queue_unit.sv */
// ----------------------------------------------------------------------------
// dedup_receive_message_queue_unit
// Receive queue that drops own and duplicate messages, notes confirms and
// heartbeats, and hands out the oldest queued message on a fetch.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid_i/in_ready_o  action_i .. now_tick_i
//  output    out_valid_o/out_ready_i status_o .. last_confirm_id_o
//  config    cfg_we_i (no wait)     cfg_wdata_i (own position)
//
// A fetch or a reliable/unreliable header from another station passes through
// an accept step, one scan step per slot/ring entry and a commit step before
// the next accept.
// Own, confirm and heartbeat headers go from accept straight to commit.
// The result register is loaded at commit; the next item is accepted while a
// result waits, and commit stalls only while the output is still held.
// Reset clears all control state, valid bits, the recent-id ring and the
// heartbeat table at once; no clearing pass.
// ----------------------------------------------------------------------------
module dedup_receive_message_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drmq_pkg::POS_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic                          remove_i,
  input  logic [drmq_pkg::POS_W-1:0]    sender_i,
  input  logic [1:0]                    msg_kind_i,
  input  logic [drmq_pkg::ID_W-1:0]     msg_id_i,
  input  logic [drmq_pkg::CMD_W-1:0]    command_i,
  input  logic [drmq_pkg::REF_W-1:0]    payload_ref_i,
  input  logic [drmq_pkg::TICK_W-1:0]   now_tick_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic                          send_confirm_o,
  output logic [drmq_pkg::POS_W-1:0]    confirm_to_o,
  output logic [drmq_pkg::ID_W-1:0]     confirm_id_o,
  output logic [drmq_pkg::POS_W-1:0]    got_sender_o,
  output logic [1:0]                    got_kind_o,
  output logic [drmq_pkg::ID_W-1:0]     got_id_o,
  output logic [drmq_pkg::CMD_W-1:0]    got_command_o,
  output logic [drmq_pkg::REF_W-1:0]    got_ref_o,
  output logic signed [drmq_pkg::LC_W-1:0] last_confirm_id_o
);

  drmq_pkg::ctl_cmd_t  cmd;
  drmq_pkg::ctl_stat_t stat;

  // Sequencer
  drmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage, scan and result
  drmq_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (action_i),
    .remove_i          (remove_i),
    .sender_i          (sender_i),
    .msg_kind_i        (msg_kind_i),
    .msg_id_i          (msg_id_i),
    .command_i         (command_i),
    .payload_ref_i     (payload_ref_i),
    .now_tick_i        (now_tick_i),
    .status_o          (status_o),
    .send_confirm_o    (send_confirm_o),
    .confirm_to_o      (confirm_to_o),
    .confirm_id_o      (confirm_id_o),
    .got_sender_o      (got_sender_o),
    .got_kind_o        (got_kind_o),
    .got_id_o          (got_id_o),
    .got_command_o     (got_command_o),
    .got_ref_o         (got_ref_o),
    .last_confirm_id_o (last_confirm_id_o)
  );

endmodule

/* hw/rtl/drmq_ctrl.sv */
// ----------------------------------------------------------------------------
// drmq_ctrl
// Sequencer: accept an item, run the slot scan when the item needs one, then
// commit the result into the output register once that register is free.
// ----------------------------------------------------------------------------
`include "dedup_receive_message_queue_unit_defines.svh"

module drmq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  drmq_pkg::ctl_stat_t  stat_i,
  output drmq_pkg::ctl_cmd_t   cmd_o
);

  drmq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drmq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      drmq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.needs_scan ? drmq_pkg::S_SCAN : drmq_pkg::S_FINISH;
        end
      end
      drmq_pkg::S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = drmq_pkg::S_FINISH;
        end
      end
      drmq_pkg::S_FINISH: begin
        // Wait until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = drmq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = drmq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `DRMQ_ASSERT_NEXT(a_load_leaves_idle, cmd_o.load, (state_q == drmq_pkg::S_SCAN) || (state_q == drmq_pkg::S_FINISH), "accepted item did not start work")
  `DRMQ_ASSERT_NEXT(a_scan_ends_finish, (state_q == drmq_pkg::S_SCAN) && stat_i.scan_last, state_q == drmq_pkg::S_FINISH, "scan did not end in finish")
  `DRMQ_ASSERT_NEXT(a_commit_shows_result, cmd_o.commit, out_valid_o && (state_q == drmq_pkg::S_IDLE), "commit did not present a result")

endmodule

/* hw/rtl/drmq_datapath.sv */
// ----------------------------------------------------------------------------
// drmq_datapath
// Slot store, recent-id ring, heartbeat table, scan unit and result register.
// One slot and one ring entry are examined per scan step.
// ----------------------------------------------------------------------------
module drmq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drmq_pkg::ctl_cmd_t            cmd_i,
  output drmq_pkg::ctl_stat_t           stat_o,
  input  logic                          cfg_we_i,
  input  logic [drmq_pkg::POS_W-1:0]    cfg_wdata_i,
  input  logic                          action_i,
  input  logic                          remove_i,
  input  logic [drmq_pkg::POS_W-1:0]    sender_i,
  input  logic [1:0]                    msg_kind_i,
  input  logic [drmq_pkg::ID_W-1:0]     msg_id_i,
  input  logic [drmq_pkg::CMD_W-1:0]    command_i,
  input  logic [drmq_pkg::REF_W-1:0]    payload_ref_i,
  input  logic [drmq_pkg::TICK_W-1:0]   now_tick_i,
  output logic [2:0]                    status_o,
  output logic                          send_confirm_o,
  output logic [drmq_pkg::POS_W-1:0]    confirm_to_o,
  output logic [drmq_pkg::ID_W-1:0]     confirm_id_o,
  output logic [drmq_pkg::POS_W-1:0]    got_sender_o,
  output logic [1:0]                    got_kind_o,
  output logic [drmq_pkg::ID_W-1:0]     got_id_o,
  output logic [drmq_pkg::CMD_W-1:0]    got_command_o,
  output logic [drmq_pkg::REF_W-1:0]    got_ref_o,
  output logic signed [drmq_pkg::LC_W-1:0] last_confirm_id_o
);

  // Configuration and persistent state
  logic [drmq_pkg::POS_W-1:0]   own_q;
  logic                         slot_valid_q [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::ORDER_W-1:0] slot_order_q [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::ID_W-1:0]    slot_id_q    [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::POS_W-1:0]   slot_sender_q[drmq_pkg::QUEUE_DEPTH];
  logic [1:0]                   slot_kind_q  [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::CMD_W-1:0]   slot_cmd_q   [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::REF_W-1:0]   slot_ref_q   [drmq_pkg::QUEUE_DEPTH];
  logic [drmq_pkg::ID_W-1:0]    recent_q     [drmq_pkg::RECENT_DEPTH];
  logic [drmq_pkg::TICK_W-1:0]  hb_time_q    [drmq_pkg::STATIONS];
  logic [drmq_pkg::ORDER_W-1:0] order_cnt_q;
  logic [drmq_pkg::RIDX_W-1:0]  recent_ptr_q;
  logic [drmq_pkg::LC_W-1:0]    last_conf_q;

  // Latched item
  logic                         act_q, rem_q;
  logic [drmq_pkg::POS_W-1:0]   sender_q;
  logic [1:0]                   kind_q;
  logic [drmq_pkg::ID_W-1:0]    id_q;
  logic [drmq_pkg::CMD_W-1:0]   cmd_q;
  logic [drmq_pkg::REF_W-1:0]   ref_q;
  logic [drmq_pkg::TICK_W-1:0]  tick_q;

  // Scan state
  logic [drmq_pkg::SIDX_W-1:0]  idx_q;
  logic                         free_found_q, dup_q, best_found_q;
  logic [drmq_pkg::QIDX_W-1:0]  free_idx_q, best_idx_q;
  logic [drmq_pkg::ORDER_W-1:0] best_order_q;
  logic [drmq_pkg::POS_W-1:0]   best_sender_q;
  logic [1:0]                   best_kind_q;
  logic [drmq_pkg::ID_W-1:0]    best_id_q;
  logic [drmq_pkg::CMD_W-1:0]   best_cmd_q;
  logic [drmq_pkg::REF_W-1:0]   best_ref_q;

  // Result register
  drmq_pkg::status_e            res_status_q;
  logic                         res_conf_q;
  logic [drmq_pkg::POS_W-1:0]   res_conf_to_q;
  logic [drmq_pkg::ID_W-1:0]    res_conf_id_q;
  logic [drmq_pkg::POS_W-1:0]   res_sender_q;
  logic [1:0]                   res_kind_q;
  logic [drmq_pkg::ID_W-1:0]    res_id_q;
  logic [drmq_pkg::CMD_W-1:0]   res_cmd_q;
  logic [drmq_pkg::REF_W-1:0]   res_ref_q;
  logic [drmq_pkg::LC_W-1:0]    res_lc_q;

  // Scan step signals
  logic [drmq_pkg::QIDX_W-1:0]  qi;
  logic [drmq_pkg::RIDX_W-1:0]  ri;
  logic                         q_in, r_in;
  logic                         s_valid;
  logic [drmq_pkg::ORDER_W-1:0] s_order;
  logic                         take_best, take_free, hit_slot, hit_ring;

  // Commit decisions
  drmq_pkg::status_e            c_status;
  logic                         c_conf;
  logic                         c_got;
  logic                         c_enqueue, c_remove, c_hb, c_lc;
  logic [drmq_pkg::LC_W-1:0]    c_lc_val;

  // Scan bookkeeping
  assign stat_o.needs_scan = (action_i == drmq_pkg::ACT_FETCH) ||
                             ((sender_i != own_q) &&
                              ((msg_kind_i == drmq_pkg::MK_RELIABLE) ||
                               (msg_kind_i == drmq_pkg::MK_UNRELIABLE)));
  assign stat_o.scan_last  = (idx_q == drmq_pkg::SIDX_W'(drmq_pkg::SCAN_LEN - 1));

  assign qi   = idx_q[drmq_pkg::QIDX_W-1:0];
  assign ri   = idx_q[drmq_pkg::RIDX_W-1:0];
  assign q_in = {1'b0, idx_q} < (drmq_pkg::SIDX_W + 1)'(drmq_pkg::QUEUE_DEPTH);
  assign r_in = {1'b0, idx_q} < (drmq_pkg::SIDX_W + 1)'(drmq_pkg::RECENT_DEPTH);

  assign s_valid   = q_in && slot_valid_q[qi];
  assign s_order   = slot_order_q[qi];
  assign take_best = s_valid && (!best_found_q || (s_order < best_order_q));
  assign take_free = q_in && !slot_valid_q[qi] && !free_found_q;
  assign hit_slot  = s_valid && (slot_id_q[qi] == id_q);
  assign hit_ring  = r_in && (recent_q[ri] == id_q);

  // Latch the item, then advance the scan one slot per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q        <= action_i;
      rem_q        <= remove_i;
      sender_q     <= sender_i;
      kind_q       <= msg_kind_i;
      id_q         <= msg_id_i;
      cmd_q        <= command_i;
      ref_q        <= payload_ref_i;
      tick_q       <= now_tick_i;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      dup_q        <= 1'b0;
      best_found_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
      if (take_best) begin
        best_found_q  <= 1'b1;
        best_idx_q    <= qi;
        best_order_q  <= s_order;
        best_sender_q <= slot_sender_q[qi];
        best_kind_q   <= slot_kind_q[qi];
        best_id_q     <= slot_id_q[qi];
        best_cmd_q    <= slot_cmd_q[qi];
        best_ref_q    <= slot_ref_q[qi];
      end
      if (take_free) begin
        free_found_q <= 1'b1;
        free_idx_q   <= qi;
      end
      if (hit_slot || hit_ring) begin
        dup_q <= 1'b1;
      end
    end
  end

  // Decide the outcome of the item
  always_comb begin
    c_status  = drmq_pkg::RS_EMPTY;
    c_conf    = 1'b0;
    c_got     = 1'b0;
    c_enqueue = 1'b0;
    c_remove  = 1'b0;
    c_hb      = 1'b0;
    c_lc      = 1'b0;
    c_lc_val  = last_conf_q;
    if (act_q == drmq_pkg::ACT_FETCH) begin
      if (best_found_q) begin
        c_status = drmq_pkg::RS_FETCHED;
        c_got    = 1'b1;
        c_remove = rem_q;
      end else begin
        c_status = drmq_pkg::RS_EMPTY;
      end
    end else if (sender_q == own_q) begin
      c_status = drmq_pkg::RS_OWN;
    end else if (kind_q == drmq_pkg::MK_CONFIRM) begin
      c_status = drmq_pkg::RS_CONFIRM;
      c_lc     = 1'b1;
      c_lc_val = {1'b0, id_q};
    end else if (kind_q == drmq_pkg::MK_HEARTBEAT) begin
      c_status = drmq_pkg::RS_HEARTBEAT;
      c_hb     = {1'b0, sender_q} < (drmq_pkg::POS_W + 1)'(drmq_pkg::STATIONS);
    end else if (!free_found_q) begin
      c_status = drmq_pkg::RS_FULL;
    end else begin
      c_conf = (kind_q == drmq_pkg::MK_RELIABLE);
      if (dup_q) begin
        c_status = drmq_pkg::RS_DUP;
      end else begin
        c_status  = drmq_pkg::RS_QUEUED;
        c_enqueue = 1'b1;
      end
    end
  end

  // Configuration and reset-cleared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q        <= '0;
      order_cnt_q  <= '0;
      recent_ptr_q <= '0;
      last_conf_q  <= '1;
      for (int i = 0; i < drmq_pkg::QUEUE_DEPTH; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
      for (int i = 0; i < drmq_pkg::RECENT_DEPTH; i++) begin
        recent_q[i] <= '0;
      end
      for (int i = 0; i < drmq_pkg::STATIONS; i++) begin
        hb_time_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        if (c_lc) begin
          last_conf_q <= c_lc_val;
        end
        if (c_hb) begin
          hb_time_q[sender_q[drmq_pkg::HB_W-1:0]] <= tick_q;
        end
        if (c_remove) begin
          slot_valid_q[best_idx_q] <= 1'b0;
        end
        if (c_enqueue) begin
          slot_valid_q[free_idx_q] <= 1'b1;
          order_cnt_q              <= order_cnt_q + 1'b1;
          recent_q[recent_ptr_q]   <= id_q;
          if (recent_ptr_q == drmq_pkg::RIDX_W'(drmq_pkg::RECENT_DEPTH - 1)) begin
            recent_ptr_q <= '0;
          end else begin
            recent_ptr_q <= recent_ptr_q + 1'b1;
          end
        end
      end
    end
  end

  // Slot payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && c_enqueue) begin
      slot_order_q[free_idx_q]  <= order_cnt_q;
      slot_id_q[free_idx_q]     <= id_q;
      slot_sender_q[free_idx_q] <= sender_q;
      slot_kind_q[free_idx_q]   <= kind_q;
      slot_cmd_q[free_idx_q]    <= cmd_q;
      slot_ref_q[free_idx_q]    <= ref_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q  <= c_status;
      res_conf_q    <= c_conf;
      res_conf_to_q <= c_conf ? sender_q : '0;
      res_conf_id_q <= c_conf ? id_q : '0;
      res_sender_q  <= c_got ? best_sender_q : '0;
      res_kind_q    <= c_got ? best_kind_q : '0;
      res_id_q      <= c_got ? best_id_q : '0;
      res_cmd_q     <= c_got ? best_cmd_q : '0;
      res_ref_q     <= c_got ? best_ref_q : '0;
      res_lc_q      <= c_lc_val;
    end
  end

  assign status_o          = res_status_q;
  assign send_confirm_o    = res_conf_q;
  assign confirm_to_o      = res_conf_to_q;
  assign confirm_id_o      = res_conf_id_q;
  assign got_sender_o      = res_sender_q;
  assign got_kind_o        = res_kind_q;
  assign got_id_o          = res_id_q;
  assign got_command_o     = res_cmd_q;
  assign got_ref_o         = res_ref_q;
  assign last_confirm_id_o = $signed(res_lc_q);

endmodule
